// ===== src/ntcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntcm_pkg: shared constants and types of the nibble trie code map
// Pool size, command and status codes, node record layout, nibble select.
// ----------------------------------------------------------------------------
package ntcm_pkg;

	localparam int NODE_POOL = 256;
	localparam int FANOUT    = 16;
	localparam int LEVELS    = 4;
	localparam int NODE_W    = $clog2(NODE_POOL);
	localparam int SLOT_W    = $clog2(FANOUT);
	localparam int LINK_AW   = NODE_W + SLOT_W;
	localparam int FC_W      = $clog2(NODE_POOL + 1);
	localparam int CNT_W     = $clog2(FANOUT + 1);

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_FIND   = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_CLEAR  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_PRESENT   = 2'd2;
	localparam logic [1:0] ST_NO_NODES  = 2'd3;

	// per-node record: child count, leaf record, parent link, free-list link
	typedef struct packed {
		logic [CNT_W-1:0]  count;
		logic              leaf_vld;
		logic [15:0]       leaf_hdl;
		logic [NODE_W-1:0] pnode;
		logic [SLOT_W-1:0] pslot;
		logic [NODE_W-1:0] next;
	} node_info_t;

	// nibble of the key for a trie level, most significant first
	function automatic logic [3:0] nib_at(logic [15:0] key, logic [1:0] lvl);
		logic [3:0] r;
		case (lvl)
			2'd0: r = key[15:12];
			2'd1: r = key[11:8];
			2'd2: r = key[7:4];
			default: r = key[3:0];
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/ntcm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ntcm_if: item channels of the nibble trie code map
// Command channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ntcm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] code_key;
	logic [15:0] record_handle_in;
	modport source (output valid, cmd, code_key, record_handle_in, input ready);
	modport sink (input valid, cmd, code_key, record_handle_in, output ready);
endinterface

interface ntcm_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] record_handle_out;
	modport source (output valid, status, record_handle_out, input ready);
	modport sink (input valid, status, record_handle_out, output ready);
endinterface
`default_nettype wire

// ===== src/nibble_trie_code_map_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nibble_trie_code_map_unit: 16-bit code to record handle map, radix-16 trie
// Link memory (node x slot) and node record memory, walked by a sequencer.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req     | in  | cmd, code_key, record_handle_in
//  rsp     | out | status, record_handle_out
//
// Find walks each level through a link read and wait state, then reads the
// leaf record and posts from the done state; a new item is taken only in idle,
// after the last has posted. Insert allocates, zeroes and links a node per
// missing level; remove prunes childless nodes up; clear sweeps the root row.
// The link memory takes one write per cycle, so rows are zeroed slot by slot.
// After reset the root row is swept slot by slot before req.ready rises.
// A waiting result sits in the output register; the next item is accepted.
// ----------------------------------------------------------------------------
module nibble_trie_code_map_unit
	import ntcm_pkg::*;
(
	input  wire    clk,
	input  wire    arst_n,
	ntcm_req_if.sink   req,
	ntcm_rsp_if.source rsp
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_CLR  = 5'd1;
	localparam logic [4:0] S_LRD  = 5'd2;
	localparam logic [4:0] S_LWT  = 5'd3;
	localparam logic [4:0] S_ARD  = 5'd4;
	localparam logic [4:0] S_AWT  = 5'd5;
	localparam logic [4:0] S_ZERO = 5'd6;
	localparam logic [4:0] S_LINK = 5'd7;
	localparam logic [4:0] S_CRD  = 5'd8;
	localparam logic [4:0] S_CWT  = 5'd9;
	localparam logic [4:0] S_FRD  = 5'd10;
	localparam logic [4:0] S_FWT  = 5'd11;
	localparam logic [4:0] S_PRD  = 5'd12;
	localparam logic [4:0] S_PWT  = 5'd13;
	localparam logic [4:0] S_DONE = 5'd14;

	localparam logic [1:0]        LVL_LAST = 2'(LEVELS - 1);
	localparam logic [SLOT_W-1:0] SWP_LAST = SLOT_W'(FANOUT - 1);

	logic [4:0]          state_q;
	logic                rep_q;
	logic [1:0]          lvl_q;
	logic [NODE_W-1:0]   node_q, alloc_q, head_q;
	logic [SLOT_W-1:0]   cnt_q;
	logic [FC_W-1:0]     fc_q;
	logic [1:0]          cmd_q;
	logic [15:0]         key_q, hdl_q;
	logic [1:0]          st_q;
	logic [15:0]         ho_q;
	logic                ov_q;
	logic [1:0]          rsp_st_q;
	logic [15:0]         rsp_ho_q;
	logic [NODE_POOL-1:0] vld_q;

	logic [NODE_W-1:0]  link_mem [NODE_POOL*FANOUT];
	node_info_t         info_mem [NODE_POOL];
	logic [NODE_W-1:0]  link_rd;
	node_info_t         info_raw, info_rd, info_wd;
	logic               hit_s1;
	logic [NODE_W-1:0]  iadr_s1;

	logic               link_we, info_we;
	logic [LINK_AW-1:0] link_ra, link_wa;
	logic [NODE_W-1:0]  link_wd, info_ra, info_wa;
	logic [SLOT_W-1:0]  slot;
	logic               acc, post;

	assign slot = nib_at(key_q, lvl_q);
	assign acc  = req.valid && req.ready;
	assign post = (state_q == S_DONE) && (!ov_q || rsp.ready);

	assign req.ready             = (state_q == S_IDLE);
	assign rsp.valid             = ov_q;
	assign rsp.status            = rsp_st_q;
	assign rsp.record_handle_out = rsp_ho_q;

	// memories, read data registered
	always_ff @(posedge clk) begin
		if (link_we)
			link_mem[link_wa] <= link_wd;
		link_rd <= link_mem[link_ra];
		if (info_we)
			info_mem[info_wa] <= info_wd;
		info_raw <= info_mem[info_ra];
		iadr_s1  <= info_ra;
	end

	// records never written since clear read as a fresh free node
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hit_s1 <= 1'b0;
		else
			hit_s1 <= vld_q[info_ra];
	end

	always_comb begin
		info_rd = info_raw;
		if (!hit_s1) begin
			info_rd      = '0;
			info_rd.next = iadr_s1 + NODE_W'(1);
		end
	end

	// memory access per state
	always_comb begin
		link_ra = {node_q, slot};
		link_we = 1'b0;
		link_wa = {node_q, slot};
		link_wd = '0;
		info_ra = node_q;
		info_we = 1'b0;
		info_wa = node_q;
		info_wd = info_rd;
		case (state_q)
			S_CLR: begin
				link_we = 1'b1;
				link_wa = {NODE_W'(0), cnt_q};
			end
			S_ARD: info_ra = head_q;
			S_AWT: begin
				info_we       = 1'b1;
				info_wa       = head_q;
				info_wd       = '0;
				info_wd.pnode = node_q;
				info_wd.pslot = slot;
			end
			S_ZERO: begin
				link_we = 1'b1;
				link_wa = {alloc_q, cnt_q};
			end
			S_LINK: begin
				link_we = 1'b1;
				link_wd = alloc_q;
			end
			S_CWT: begin
				info_we = 1'b1;
				if (cmd_q == CMD_INSERT) begin
					if (info_rd.count < CNT_W'(FANOUT))
						info_wd.count = info_rd.count + CNT_W'(1);
				end else if (info_rd.count != '0) begin
					info_wd.count = info_rd.count - CNT_W'(1);
				end
			end
			S_FWT: begin
				if (cmd_q == CMD_REMOVE && info_rd.leaf_vld) begin
					info_we          = 1'b1;
					info_wd.leaf_vld = 1'b0;
					info_wd.leaf_hdl = '0;
				end else if (cmd_q == CMD_INSERT && !info_rd.leaf_vld) begin
					info_we          = 1'b1;
					info_wd.leaf_vld = 1'b1;
					info_wd.leaf_hdl = hdl_q;
				end
			end
			S_PWT: begin
				if (info_rd.count == '0) begin
					link_we      = 1'b1;
					link_wa      = {info_rd.pnode, info_rd.pslot};
					info_we      = 1'b1;
					info_wd.next = head_q;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			rep_q   <= 1'b0;
			cnt_q   <= '0;
			vld_q   <= '0;
			head_q  <= NODE_W'(1);
			fc_q    <= FC_W'(NODE_POOL - 1);
			lvl_q   <= '0;
			node_q  <= '0;
			alloc_q <= '0;
			cmd_q   <= CMD_FIND;
			key_q   <= '0;
			hdl_q   <= '0;
			st_q    <= ST_OK;
			ho_q    <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (info_we)
				vld_q[info_wa] <= 1'b1;
			if (post)
				ov_q <= 1'b1;
			else if (rsp.ready)
				ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						cmd_q  <= req.cmd;
						key_q  <= req.code_key;
						hdl_q  <= req.record_handle_in;
						rep_q  <= 1'b1;
						lvl_q  <= '0;
						node_q <= '0;
						st_q   <= ST_OK;
						ho_q   <= '0;
						if (req.cmd == CMD_CLEAR) begin
							vld_q   <= '0;
							head_q  <= NODE_W'(1);
							fc_q    <= FC_W'(NODE_POOL - 1);
							cnt_q   <= '0;
							state_q <= S_CLR;
						end else begin
							state_q <= S_LRD;
						end
					end
				end
				S_CLR: begin
					cnt_q <= cnt_q + SLOT_W'(1);
					if (cnt_q == SWP_LAST)
						state_q <= rep_q ? S_DONE : S_IDLE;
				end
				S_LRD: state_q <= S_LWT;
				S_LWT: begin
					if (link_rd != '0) begin
						node_q <= link_rd;
						if (lvl_q == LVL_LAST) begin
							state_q <= S_FRD;
						end else begin
							lvl_q   <= lvl_q + 2'd1;
							state_q <= S_LRD;
						end
					end else if (cmd_q == CMD_INSERT) begin
						if (fc_q == '0) begin
							st_q    <= ST_NO_NODES;
							state_q <= S_DONE;
						end else begin
							state_q <= S_ARD;
						end
					end else begin
						st_q    <= ST_NOT_FOUND;
						state_q <= S_DONE;
					end
				end
				S_ARD: state_q <= S_AWT;
				S_AWT: begin
					alloc_q <= head_q;
					head_q  <= info_rd.next;
					fc_q    <= fc_q - FC_W'(1);
					cnt_q   <= '0;
					state_q <= S_ZERO;
				end
				S_ZERO: begin
					cnt_q <= cnt_q + SLOT_W'(1);
					if (cnt_q == SWP_LAST)
						state_q <= S_LINK;
				end
				S_LINK: state_q <= S_CRD;
				S_CRD: state_q <= S_CWT;
				S_CWT: begin
					if (cmd_q == CMD_INSERT) begin
						node_q <= alloc_q;
						if (lvl_q == LVL_LAST) begin
							state_q <= S_FRD;
						end else begin
							lvl_q   <= lvl_q + 2'd1;
							state_q <= S_LRD;
						end
					end else begin
						state_q <= S_PRD;
					end
				end
				S_FRD: state_q <= S_FWT;
				S_FWT: begin
					if (cmd_q == CMD_REMOVE && info_rd.leaf_vld)
						state_q <= S_PRD;
					else
						state_q <= S_DONE;
					if (cmd_q == CMD_INSERT) begin
						st_q <= info_rd.leaf_vld ? ST_PRESENT : ST_OK;
					end else if (!info_rd.leaf_vld) begin
						st_q <= ST_NOT_FOUND;
					end else if (cmd_q == CMD_FIND) begin
						ho_q <= info_rd.leaf_hdl;
					end
				end
				// prune upward while the node is childless and not the root
				S_PRD: state_q <= (node_q == '0) ? S_DONE : S_PWT;
				S_PWT: begin
					if (info_rd.count != '0) begin
						state_q <= S_DONE;
					end else begin
						head_q  <= node_q;
						fc_q    <= fc_q + FC_W'(1);
						node_q  <= info_rd.pnode;
						state_q <= S_CRD;
					end
				end
				S_DONE: if (post) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (post) begin
			rsp_st_q <= st_q;
			rsp_ho_q <= ho_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_fc_range: assert property (@(posedge clk) disable iff (!arst_n)
		fc_q <= FC_W'(NODE_POOL - 1))
		else $error("free node count above pool size");
	a_busy_after_acc: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q != S_IDLE)
		else $error("sequencer idle after accepting an item");
	a_miss_no_handle: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && rsp_st_q != ST_OK |-> rsp_ho_q == '0)
		else $error("handle returned with a failing status");
	a_alloc_nonroot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ZERO |-> alloc_q != '0)
		else $error("root handed out as a new node");
`endif

endmodule
`default_nettype wire
